### hdl/pf_pkg.sv
// shared types and constants for the playfair digraph cipher
// no dependencies; imported by every module of the block
package pf_pkg;

    localparam int GRID_SIDE  = 5;
    localparam int CHAR_BITS  = 8;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int CELL_IDX_W = $clog2(CELL_COUNT);

    // fixed field widths of the stream items
    localparam int CMD_W      = 1;
    localparam int IDX_W      = 5;
    localparam int LETTER_W   = 8;
    localparam int STATUS_W   = 1;

    // stream and register port widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CMD_W-1:0]     CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0]     CMD_PAIR = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 1'b0;

    localparam logic [STATUS_W-1:0]  STATUS_OK       = 1'b0;
    localparam logic [STATUS_W-1:0]  STATUS_NOT_FOUND = 1'b1;

    typedef logic [CELL_COUNT-1:0][CHAR_BITS-1:0] square_t;
    typedef logic [COORD_W-1:0] coord_t;

    // after the compare stage
    typedef struct packed {
        logic [CELL_COUNT-1:0] hit_a;
        logic [CELL_COUNT-1:0] hit_b;
        square_t               square;
    } match_t;

    // after the locate stage
    typedef struct packed {
        coord_t  row_a;
        coord_t  col_a;
        coord_t  row_b;
        coord_t  col_b;
        logic    found;
        square_t square;
    } locate_t;

    // after the select stage
    typedef struct packed {
        logic [CELL_COUNT-1:0] sel_a;
        logic [CELL_COUNT-1:0] sel_b;
        logic                  found;
        square_t               square;
    } select_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_first;
        logic [LETTER_W-1:0] out_second;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

### hdl/pf_match.sv
// key square storage and first pipeline stage: parallel letter compare
// depends on pf_pkg
module pf_match (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load_en,
    input  logic [pf_pkg::IDX_W-1:0]     cell_index,
    input  logic [pf_pkg::LETTER_W-1:0]  cell_letter,
    input  logic                         pair_valid,
    input  logic [pf_pkg::LETTER_W-1:0]  first_letter,
    input  logic [pf_pkg::LETTER_W-1:0]  second_letter,
    output logic                         in_ready,
    input  logic                         out_ready,
    output logic                         valid,
    output pf_pkg::match_t               stage
);
    import pf_pkg::*;

    square_t    square_reg;
    logic       valid_reg;
    logic       valid_next;
    match_t     stage_reg;
    match_t     stage_next;
    logic [CHAR_BITS-1:0] key_a;
    logic [CHAR_BITS-1:0] key_b;

    assign in_ready = !valid_reg || out_ready;
    assign key_a    = first_letter[CHAR_BITS-1:0];
    assign key_b    = second_letter[CHAR_BITS-1:0];

    always_comb
    begin
        stage_next.square = square_reg;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            stage_next.hit_a[k] = (square_reg[k] == key_a);
            stage_next.hit_b[k] = (square_reg[k] == key_b);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = pair_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid && in_ready)
        begin
            stage_reg <= stage_next;
        end
        if (load_en && (32'(cell_index) < CELL_COUNT))
        begin
            square_reg[CELL_IDX_W'(cell_index)] <= cell_letter[CHAR_BITS-1:0];
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

### hdl/pf_locate.sv
// second pipeline stage: last matching cell to row and column
// depends on pf_pkg
module pf_locate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pf_pkg::match_t    in_stage,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              valid,
    output pf_pkg::locate_t   stage
);
    import pf_pkg::*;

    typedef struct packed {
        logic   found;
        coord_t row;
        coord_t col;
    } loc_t;

    logic    valid_reg;
    logic    valid_next;
    locate_t stage_reg;
    locate_t stage_next;
    loc_t    loc_a;
    loc_t    loc_b;

    // highest row with a hit, then highest column in that row
    function automatic loc_t find_last(input logic [CELL_COUNT-1:0] hit);
        loc_t                 res;
        logic [GRID_SIDE-1:0] row_hit;
        logic [GRID_SIDE-1:0] col_hit;
        res     = '0;
        row_hit = '0;
        col_hit = '0;
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            for (int c = 0; c < GRID_SIDE; c++)
            begin
                row_hit[r] = row_hit[r] | hit[r * GRID_SIDE + c];
            end
        end
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            if (row_hit[r])
            begin
                res.row = COORD_W'(r);
            end
        end
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            for (int c = 0; c < GRID_SIDE; c++)
            begin
                if (res.row == COORD_W'(r))
                begin
                    col_hit[c] = hit[r * GRID_SIDE + c];
                end
            end
        end
        for (int c = 0; c < GRID_SIDE; c++)
        begin
            if (col_hit[c])
            begin
                res.col = COORD_W'(c);
            end
        end
        res.found = |hit;
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        loc_a              = find_last(in_stage.hit_a);
        loc_b              = find_last(in_stage.hit_b);
        stage_next.row_a   = loc_a.row;
        stage_next.col_a   = loc_a.col;
        stage_next.row_b   = loc_b.row;
        stage_next.col_b   = loc_b.col;
        stage_next.found   = loc_a.found && loc_b.found;
        stage_next.square  = in_stage.square;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

### hdl/pf_select.sv
// third pipeline stage: playfair rule, wraparound and one-hot cell selects
// depends on pf_pkg
module pf_select (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              direction,
    input  logic              in_valid,
    input  pf_pkg::locate_t   in_stage,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              valid,
    output pf_pkg::select_t   stage
);
    import pf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    select_t stage_reg;
    select_t stage_next;
    coord_t  row_a;
    coord_t  col_a;
    coord_t  row_b;
    coord_t  col_b;

    // one step forward (encrypt) or back (decrypt) around the square
    function automatic coord_t shift(input coord_t pos, input logic back);
        coord_t res;
        if (back)
        begin
            res = (pos == '0) ? COORD_W'(GRID_SIDE - 1) : pos - 1'b1;
        end
        else
        begin
            res = (pos == COORD_W'(GRID_SIDE - 1)) ? '0 : pos + 1'b1;
        end
        return res;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (in_stage.row_a == in_stage.row_b)
        begin
            row_a = in_stage.row_a;
            col_a = shift(in_stage.col_a, direction);
            row_b = in_stage.row_b;
            col_b = shift(in_stage.col_b, direction);
        end
        else if (in_stage.col_a == in_stage.col_b)
        begin
            row_a = shift(in_stage.row_a, direction);
            col_a = in_stage.col_a;
            row_b = shift(in_stage.row_b, direction);
            col_b = in_stage.col_b;
        end
        else
        begin
            row_a = in_stage.row_a;
            col_a = in_stage.col_b;
            row_b = in_stage.row_b;
            col_b = in_stage.col_a;
        end
    end

    always_comb
    begin
        stage_next.found  = in_stage.found;
        stage_next.square = in_stage.square;
        for (int r = 0; r < GRID_SIDE; r++)
        begin
            for (int c = 0; c < GRID_SIDE; c++)
            begin
                stage_next.sel_a[r * GRID_SIDE + c] = in_stage.found
                    && (row_a == COORD_W'(r)) && (col_a == COORD_W'(c));
                stage_next.sel_b[r * GRID_SIDE + c] = in_stage.found
                    && (row_b == COORD_W'(r)) && (col_b == COORD_W'(c));
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

### hdl/pf_gather.sv
// last pipeline stage: and-or read of the selected cells into the output register
// depends on pf_pkg
module pf_gather (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  pf_pkg::select_t   in_stage,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              valid,
    output pf_pkg::result_t   result
);
    import pf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    result_t result_next;
    logic [CHAR_BITS-1:0] pick_a;
    logic [CHAR_BITS-1:0] pick_b;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        pick_a = '0;
        pick_b = '0;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            pick_a = pick_a | (in_stage.square[k] & {CHAR_BITS{in_stage.sel_a[k]}});
            pick_b = pick_b | (in_stage.square[k] & {CHAR_BITS{in_stage.sel_b[k]}});
        end
        result_next.out_first  = LETTER_W'(pick_a);
        result_next.out_second = LETTER_W'(pick_b);
        result_next.status     = in_stage.found ? STATUS_OK : STATUS_NOT_FOUND;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

### hdl/playfair_digraph_cipher.sv
// top level of the playfair digraph cipher: stream ports, register port, pipeline
// depends on pf_pkg, pf_match, pf_locate, pf_select, pf_gather
//
// Playfair substitution of letter pairs over a 5x5 key square held in
// flip-flops. A stream transaction with tuser = 0 writes one square cell
// (an index past the last cell is dropped) and produces no result; with
// tuser = 1 it carries a letter pair and produces exactly one result
// transaction. The block takes one transaction per cycle while the output is
// not stalled; its pipeline is four registers deep (compare, locate, select,
// gather), passed in that order before a result shows on the output. Each
// stage holds its item under backpressure and a stage that is empty keeps
// taking items, so the input stays ready until all four stages are full. A
// cell write takes effect for the very next transaction. Every cell must be
// written after reset before the first pair; a letter found in several cells
// uses the last of them in row-major order, and a letter not in the square
// gives status 1 with both output letters zero. The direction register (0
// encrypt, 1 decrypt, byte address 0) must be changed by the user only while
// no pair is in flight; the block itself does not enforce this.
module playfair_digraph_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata fields from bit 0: cell_index[4:0], cell_letter[12:5],
    // first_letter[20:13], second_letter[28:21], zero[31:29]
    input  logic [pf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser fields from bit 0: cmd[0]
    input  logic [pf_pkg::CMD_W-1:0]        s_axis_tuser,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata fields from bit 0: out_first[7:0], out_second[15:8]
    output logic [pf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser fields from bit 0: status[0]
    output logic [pf_pkg::STATUS_W-1:0]     m_axis_tuser,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready
);
    import pf_pkg::*;

    // input field unpacking
    logic [IDX_W-1:0]    cell_index;
    logic [LETTER_W-1:0] cell_letter;
    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
    logic                in_fire;
    logic                load_en;
    logic                pair_valid;

    // register file
    logic                 direction_reg;
    logic                 direction_next;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 reg_write;

    // pipeline handshakes between stages
    logic    match_valid;
    logic    locate_valid;
    logic    select_valid;
    logic    locate_ready;
    logic    select_ready;
    logic    gather_ready;
    match_t  match_stage;
    locate_t locate_stage;
    select_t select_stage;
    result_t result;

    assign cell_index    = s_axis_tdata[IDX_W-1:0];
    assign cell_letter   = s_axis_tdata[IDX_W +: LETTER_W];
    assign first_letter  = s_axis_tdata[IDX_W + LETTER_W +: LETTER_W];
    assign second_letter = s_axis_tdata[IDX_W + 2 * LETTER_W +: LETTER_W];

    // a cell write is done at the transaction itself, so a pair right behind
    // it already compares against the new cell
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign load_en    = in_fire && (s_axis_tuser == CMD_LOAD);
    assign pair_valid = s_axis_tvalid && (s_axis_tuser == CMD_PAIR);

    // register access: one register, word aligned
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        direction_next = direction_reg;
        if (reg_write && (reg_index == REG_DIRECTION))
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DIRECTION: prdata = APB_DATA_W'(direction_reg);
            default:       prdata = '0;
        endcase
    end

    // stage 1: square storage and parallel compare of both letters
    pf_match u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (load_en),
        .cell_index   (cell_index),
        .cell_letter  (cell_letter),
        .pair_valid   (pair_valid),
        .first_letter (first_letter),
        .second_letter(second_letter),
        .in_ready     (s_axis_tready),
        .out_ready    (locate_ready),
        .valid        (match_valid),
        .stage        (match_stage)
    );

    // stage 2: last hit to row and column
    pf_locate u_locate (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (match_valid),
        .in_stage (match_stage),
        .in_ready (locate_ready),
        .out_ready(select_ready),
        .valid    (locate_valid),
        .stage    (locate_stage)
    );

    // stage 3: substitution rule and target cell selects
    pf_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .direction(direction_reg),
        .in_valid (locate_valid),
        .in_stage (locate_stage),
        .in_ready (select_ready),
        .out_ready(gather_ready),
        .valid    (select_valid),
        .stage    (select_stage)
    );

    // stage 4: read out the target cells, output register
    pf_gather u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (select_valid),
        .in_stage (select_stage),
        .in_ready (gather_ready),
        .out_ready(m_axis_tready),
        .valid    (m_axis_tvalid),
        .result   (result)
    );

    assign m_axis_tdata = {result.out_second, result.out_first};
    assign m_axis_tuser = result.status;

endmodule

### hdl/pf_checker.sv
// port-level checks for the playfair digraph cipher, bound to the top level
// depends on pf_pkg and playfair_digraph_cipher
module pf_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [pf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [pf_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  logic                            psel,
    input  logic                            pwrite,
    input  logic [pf_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                            pready
);
    import pf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a miss carries zero letters
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_NOT_FOUND) |-> m_axis_tdata == '0)
        else $error("miss with nonzero letters");

    // with an empty output register the pipeline cannot be full
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready with empty output");

    // only the direction bit reads back, and the port never waits
    a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> pready && (prdata[APB_DATA_W-1:1] == '0))
        else $error("bad register read");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .pwrite       (pwrite),
    .prdata       (prdata),
    .pready       (pready)
);

### sim/tb_top.sv
// self-checking testbench for playfair_digraph_cipher: stream stimulus, register writes,
// a result checker and an in-bench predictor of the key-square substitution
// depends on pf_pkg and the playfair_digraph_cipher rtl
module tb_top;
    import pf_pkg::*;

    // four pipeline registers between a pair and its result
    localparam int PIPE_DEPTH  = 4;
    localparam int MAX_GAP     = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;

    // register index with no register behind it
    localparam logic [REG_IDX_W-1:0]  REG_UNUSED     = 1'b1;
    localparam logic [APB_ADDR_W-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = {REG_UNUSED, 2'b00};

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input stream, driven by the pair/load sender
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata fields from bit 0: cell_index[4:0], cell_letter[12:5],
    // first_letter[20:13], second_letter[28:21], zero[31:29]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // tuser fields from bit 0: cmd[0]
    logic [CMD_W-1:0]      s_axis_tuser  = CMD_LOAD;

    // output stream, taken by the result checker
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata fields from bit 0: out_first[7:0], out_second[15:8]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser fields from bit 0: status[0]
    logic [STATUS_W-1:0]   m_axis_tuser;

    // register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: our own copy of the key square and the direction bit
    logic [CHAR_BITS-1:0]  square_copy [CELL_COUNT];
    logic                  cur_direction;
    // substituted pairs still owed by the block, oldest first
    result_t               expected_pairs [$];

    int                    error_count;
    int                    cycle_count;
    // when set, neither side idles, so transactions run back to back
    bit                    quiet_flow;

    playfair_digraph_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // period of 2 time units
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    // idle cycles before the next transaction on either side
    function automatic int draw_gap();
        if (quiet_flow)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        error_count++;
    endtask

    // letter held by the square cell at row, col, both taken modulo the side
    function automatic logic [LETTER_W-1:0] square_cell(int row, int col);
        return LETTER_W'(square_copy[(row % GRID_SIDE) * GRID_SIDE + (col % GRID_SIDE)]);
    endfunction

    // playfair substitution of one pair against the copied square
    function automatic result_t substitute_pair(logic [LETTER_W-1:0] first,
                                                logic [LETTER_W-1:0] second);
        result_t              res;
        logic [CHAR_BITS-1:0] a;
        logic [CHAR_BITS-1:0] b;
        int                   ra;
        int                   ca;
        int                   rb;
        int                   cb;
        int                   step;
        bit                   found_a;
        bit                   found_b;
        res     = '0;
        a       = first[CHAR_BITS-1:0];
        b       = second[CHAR_BITS-1:0];
        ra      = 0;
        ca      = 0;
        rb      = 0;
        cb      = 0;
        found_a = 1'b0;
        found_b = 1'b0;
        // scan the whole square so the last matching cell wins
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            if (square_copy[k] == a)
            begin
                ra      = k / GRID_SIDE;
                ca      = k % GRID_SIDE;
                found_a = 1'b1;
            end
            if (square_copy[k] == b)
            begin
                rb      = k / GRID_SIDE;
                cb      = k % GRID_SIDE;
                found_b = 1'b1;
            end
        end
        if (!found_a || !found_b)
        begin
            res.status = STATUS_NOT_FOUND;
            return res;
        end
        // decrypt steps back by one, which is side minus one with wraparound
        step = cur_direction ? GRID_SIDE - 1 : 1;
        if (ra == rb)
        begin
            // same row, including both letters in one cell
            res.out_first  = square_cell(ra, ca + step);
            res.out_second = square_cell(rb, cb + step);
        end
        else if (ca == cb)
        begin
            res.out_first  = square_cell(ra + step, ca);
            res.out_second = square_cell(rb + step, cb);
        end
        else
        begin
            // rectangle: swap columns
            res.out_first  = square_cell(ra, cb);
            res.out_second = square_cell(rb, ca);
        end
        res.status = STATUS_OK;
        return res;
    endfunction

    // one input transaction; the predictor runs at the edge that accepts it
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                             logic [LETTER_W-1:0] letter, logic [LETTER_W-1:0] first,
                             logic [LETTER_W-1:0] second);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, second, first, letter, idx};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        if (cmd == CMD_LOAD)
        begin
            // indexes past the last cell are dropped by the block
            if (idx < CELL_COUNT)
                square_copy[idx] = letter[CHAR_BITS-1:0];
        end
        else
            expected_pairs.push_back(substitute_pair(first, second));
    endtask

    // unused fields carry random bits so every bit toggles
    task automatic load_cell(logic [IDX_W-1:0] idx, logic [LETTER_W-1:0] letter);
        send_item(CMD_LOAD, idx, letter, LETTER_W'($urandom), LETTER_W'($urandom));
    endtask

    task automatic send_pair(logic [LETTER_W-1:0] first, logic [LETTER_W-1:0] second);
        send_item(CMD_PAIR, IDX_W'($urandom), LETTER_W'($urandom), first, second);
    endtask

    // drain: all results back, then idle so the pipeline settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[APB_ADDR_W-1:2] == REG_DIRECTION)
            cur_direction = data[0];
    endtask

    task automatic check_direction_reg();
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DIRECTION;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(cur_direction))
            report_mismatch("direction readback", got, APB_DATA_W'(cur_direction));
    endtask

    // change direction only when nothing is in flight, upper data bits are noise
    task automatic set_direction(logic dir);
        wait_idle();
        write_reg(ADDR_DIRECTION, {$urandom} & ~32'h1 | APB_DATA_W'(dir));
        check_direction_reg();
    endtask

    // letters of the directed square: 0x00 in the first cell, 0xff in the last
    function automatic logic [LETTER_W-1:0] directed_letter(int k);
        if (k == 0)
            return 8'h00;
        if (k == CELL_COUNT - 1)
            return 8'hff;
        return LETTER_W'(8'h40 + k);
    endfunction

    // distinct random letters in every cell, so all lookups are unambiguous
    task automatic load_random_square();
        bit                  used [256];
        logic [LETTER_W-1:0] v;
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            do v = LETTER_W'($urandom_range(0, 255)); while (used[v]);
            used[v] = 1'b1;
            load_cell(IDX_W'(k), v);
        end
    endtask

    // reset value, the unused register address, both direction values
    task automatic test_register_access();
        check_direction_reg();
        write_reg(ADDR_UNUSED, 32'hffff_ffff);
        check_direction_reg();
        write_reg(ADDR_DIRECTION, 32'h0000_0001);
        check_direction_reg();
        write_reg(ADDR_DIRECTION, 32'hffff_fffe);
        check_direction_reg();
    endtask

    // every substitution rule on a known square, run once per direction
    task automatic test_directed_pairs();
        for (int k = 0; k < CELL_COUNT; k++)
            load_cell(IDX_W'(k), directed_letter(k));
        for (int pass = 0; pass < 2; pass++)
        begin
            set_direction(pass[0]);
            quiet_flow = (pass == 0);
            // same row, wrapping past the last column
            send_pair(directed_letter(1), directed_letter(4));
            send_pair(directed_letter(20), directed_letter(24));
            // same column, wrapping past the last row
            send_pair(directed_letter(2), directed_letter(22));
            // rectangle, and the extreme letters in opposite corners
            send_pair(directed_letter(6), directed_letter(18));
            send_pair(directed_letter(0), directed_letter(24));
            // both letters in one cell
            send_pair(directed_letter(12), directed_letter(12));
            // letters missing from the square
            send_pair(8'h80, directed_letter(5));
            send_pair(directed_letter(7), 8'h7f);
            send_pair(8'haa, 8'hc3);
        end
        quiet_flow = 1'b0;
    endtask

    // a letter in two cells resolves to the later one
    task automatic test_duplicate_letters();
        set_direction(1'b0);
        load_cell(IDX_W'(13), directed_letter(3));
        send_pair(directed_letter(3), directed_letter(10));
        send_pair(directed_letter(3), directed_letter(8));
        // the overwritten letter is gone now
        send_pair(directed_letter(13), directed_letter(1));
    endtask

    // loads past the last cell must not touch the square
    task automatic test_out_of_range_load();
        load_cell(IDX_W'(CELL_COUNT), directed_letter(13));
        load_cell({IDX_W{1'b1}}, directed_letter(13));
        send_pair(directed_letter(13), directed_letter(1));
        send_pair(directed_letter(9), directed_letter(16));
    endtask

    // random pairs mostly drawn from the square, with stray loads and noise
    task automatic test_random_traffic();
        int                  r;
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase < 2)
                set_direction(phase[0]);
            else
                set_direction(1'($urandom_range(0, 1)));
            load_random_square();
            for (int n = 0; n < 65; n++)
            begin
                // occasional switch between idling and back-to-back stretches
                if ($urandom_range(0, 39) == 0)
                    quiet_flow = !quiet_flow;
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    a = ($urandom_range(0, 99) < 85) ?
                        LETTER_W'(square_copy[CELL_IDX_W'($urandom_range(0,
                                                                CELL_COUNT - 1))]) :
                        LETTER_W'($urandom_range(0, 255));
                    b = ($urandom_range(0, 99) < 85) ?
                        LETTER_W'(square_copy[CELL_IDX_W'($urandom_range(0,
                                                                CELL_COUNT - 1))]) :
                        LETTER_W'($urandom_range(0, 255));
                    send_pair(a, b);
                end
                else if (r < 92)
                    load_cell(IDX_W'($urandom_range(0, CELL_COUNT - 1)),
                              LETTER_W'($urandom_range(0, 255)));
                else
                    load_cell(IDX_W'($urandom_range(CELL_COUNT, 31)),
                              LETTER_W'($urandom_range(0, 255)));
            end
        end
        quiet_flow = 1'b0;
    endtask

    // result side: random backpressure, each transaction checked against the oldest pair
    initial
    begin : result_check
        result_t want;
        int      stall;
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            if (expected_pairs.size() == 0)
                report_mismatch("result with no pair pending", 32'(m_axis_tdata), '0);
            else
            begin
                want = expected_pairs.pop_front();
                if (m_axis_tdata[7:0] !== want.out_first)
                    report_mismatch("out_first", 32'(m_axis_tdata[7:0]), 32'(want.out_first));
                if (m_axis_tdata[15:8] !== want.out_second)
                    report_mismatch("out_second", 32'(m_axis_tdata[15:8]),
                                    32'(want.out_second));
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
            end
        end
    end

    // test sequence
    initial
    begin
        error_count   = 0;
        cur_direction = 1'b0;
        quiet_flow    = 1'b0;
        for (int k = 0; k < CELL_COUNT; k++)
            square_copy[k] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_pairs();
        test_duplicate_letters();
        test_out_of_range_load();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### files.f
hdl/pf_pkg.sv
hdl/pf_match.sv
hdl/pf_locate.sv
hdl/pf_select.sv
hdl/pf_gather.sv
hdl/playfair_digraph_cipher.sv
hdl/pf_checker.sv
sim/tb_top.sv
